/* rtl/h2r_pkg.sv */
// Shared constants, types and helpers for the HSV to RGB888 converter.
`default_nettype none

package h2r_pkg;

   // Field widths
   localparam int IN_W          = 16;
   localparam int OUT_W         = 8;
   localparam int FRACTION_BITS = 16;
   localparam int X_W           = FRACTION_BITS + 1;

   // Factor and product widths
   localparam int K_W = 32;
   localparam int N_W = K_W + IN_W;

   // Pipeline depth: three factor stages, six channel stages
   localparam int FACTOR_STAGES = 3;
   localparam int CHAN_STAGES   = 6;
   localparam int LATENCY       = FACTOR_STAGES + CHAN_STAGES;

   // Full-scale factor, 65535 * 65536
   localparam logic [K_W-1:0] K_ONE = 32'hFFFF_0000;

   // Divisor used in the two constant divisions
   localparam logic [17:0] DIV_ONE = 18'd65535;
   localparam logic [17:0] DIV_TWO = 18'd131070;

   // Hue sectors
   typedef enum logic [2:0] {
      SECT_RED_YEL  = 3'd0,
      SECT_YEL_GRN  = 3'd1,
      SECT_GRN_CYN  = 3'd2,
      SECT_CYN_BLU  = 3'd3,
      SECT_BLU_MAG  = 3'd4,
      SECT_MAG_RED  = 3'd5
   } sector_type;

   // Word from the factor stages to the channel stages
   typedef struct packed {
      logic            valid;
      logic [IN_W-1:0] v;
      logic [K_W-1:0]  kr;
      logic [K_W-1:0]  kg;
      logic [K_W-1:0]  kb;
   } h2r_fac_type;

   // Quotient correction for a residue below 3 * 65535 divided by 65535
   function automatic logic [1:0] div_corr(input logic [17:0] w);
      logic [1:0] c;
      c = 2'd0;
      if (w >= DIV_TWO) begin
         c = 2'd2;
      end else if (w >= DIV_ONE) begin
         c = 2'd1;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/h2r_factor.sv */
// Sector split and p/q/t factor selection: three pipeline stages.
`default_nettype none

module h2r_factor
   import h2r_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire logic [IN_W-1:0] hue,
   input  wire logic [IN_W-1:0] saturation,
   input  wire logic [IN_W-1:0] brightness,
   output h2r_fac_type          fac_out
);

   // Stage 1: hue times six, split into sector and fraction
   logic [18:0]     h6;
   logic [2:0]      s1_sector_in;
   logic [IN_W-1:0] s1_f_in;
   logic            s1_valid_ff;
   logic [2:0]      s1_sector_ff;
   logic [IN_W-1:0] s1_f_ff;
   logic [IN_W-1:0] s1_s_ff;
   logic [IN_W-1:0] s1_v_ff;

   assign h6           = 19'({hue, 2'b00}) + 19'({hue, 1'b0});
   assign s1_sector_in = h6[18:16];
   assign s1_f_in      = h6[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_sector_ff <= s1_sector_in;
      s1_f_ff      <= s1_f_in;
      s1_s_ff      <= saturation;
      s1_v_ff      <= brightness;
   end

   // Stage 2: f*S and (1-f)*S
   logic [16:0]     g;
   logic [K_W-1:0]  fs_in;
   logic [K_W-1:0]  gs_in;
   logic            s2_valid_ff;
   logic [2:0]      s2_sector_ff;
   logic [IN_W-1:0] s2_s_ff;
   logic [IN_W-1:0] s2_v_ff;
   logic [K_W-1:0]  s2_fs_ff;
   logic [K_W-1:0]  s2_gs_ff;

   assign g     = 17'h1_0000 - {1'b0, s1_f_ff};
   assign gs_in = 32'(g) * 32'(s1_s_ff);
   assign fs_in = 32'(s1_f_ff) * 32'(s1_s_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_sector_ff <= s1_sector_ff;
      s2_s_ff      <= s1_s_ff;
      s2_v_ff      <= s1_v_ff;
      s2_fs_ff     <= fs_in;
      s2_gs_ff     <= gs_in;
   end

   // Stage 3: form p, q, t and put them in the sector's channel order
   logic [K_W-1:0] kp;
   logic [K_W-1:0] kq;
   logic [K_W-1:0] kt;
   h2r_fac_type    fac_in;
   h2r_fac_type    fac_ff;

   assign kp = {16'hFFFF - s2_s_ff, 16'h0000};
   assign kq = K_ONE - s2_fs_ff;
   assign kt = K_ONE - s2_gs_ff;

   always_comb begin
      fac_in.valid = s2_valid_ff;
      fac_in.v     = s2_v_ff;
      case (sector_type'(s2_sector_ff))
         SECT_RED_YEL: begin
            fac_in.kr = K_ONE; fac_in.kg = kt;    fac_in.kb = kp;
         end
         SECT_YEL_GRN: begin
            fac_in.kr = kq;    fac_in.kg = K_ONE; fac_in.kb = kp;
         end
         SECT_GRN_CYN: begin
            fac_in.kr = kp;    fac_in.kg = K_ONE; fac_in.kb = kt;
         end
         SECT_CYN_BLU: begin
            fac_in.kr = kp;    fac_in.kg = kq;    fac_in.kb = K_ONE;
         end
         SECT_BLU_MAG: begin
            fac_in.kr = kt;    fac_in.kg = kp;    fac_in.kb = K_ONE;
         end
         default: begin
            fac_in.kr = K_ONE; fac_in.kg = kp;    fac_in.kb = kq;
         end
      endcase
   end

   // Hold the factor word; only its valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         fac_ff.valid <= 1'b0;
      end else begin
         fac_ff.valid <= fac_in.valid;
      end
      fac_ff.v  <= fac_in.v;
      fac_ff.kr <= fac_in.kr;
      fac_ff.kg <= fac_in.kg;
      fac_ff.kb <= fac_in.kb;
   end

   assign fac_out = fac_ff;

endmodule

`default_nettype wire

/* rtl/h2r_chan.sv */
// One color channel: scale by V, divide by 65535 twice, quantize to eight bits.
`default_nettype none

module h2r_chan
   import h2r_pkg::*;
(
   input  wire logic             clock,
   input  wire logic [IN_W-1:0]  v,
   input  wire logic [K_W-1:0]   k,
   output wire logic [OUT_W-1:0] level
);

   // Stage 4: channel numerator V*K
   logic [N_W-1:0] n_ff;

   always_ff @(posedge clock) begin
      n_ff <= N_W'(v) * N_W'(k);
   end

   // Stage 5: fold n = hi*65536 + lo into hi + lo
   logic [K_W-1:0] hi_ff;
   logic [32:0]    a_ff;

   always_ff @(posedge clock) begin
      hi_ff <= n_ff[47:16];
      a_ff  <= 33'(n_ff[47:16]) + 33'(n_ff[15:0]);
   end

   // Stage 6: fold the residue once more
   logic [K_W-1:0] hpa_ff;
   logic [17:0]    w_ff;

   always_ff @(posedge clock) begin
      hpa_ff <= hi_ff + 32'(a_ff[32:16]);
      w_ff   <= 18'(a_ff[32:16]) + 18'(a_ff[15:0]);
   end

   // Stage 7: first quotient, floor(n / 65535)
   logic [K_W-1:0] q1_ff;

   always_ff @(posedge clock) begin
      q1_ff <= hpa_ff + 32'(div_corr(w_ff));
   end

   // Stage 8: fold the first quotient
   logic [15:0] hi2_ff;
   logic [16:0] a2_ff;

   always_ff @(posedge clock) begin
      hi2_ff <= q1_ff[31:16];
      a2_ff  <= 17'(q1_ff[31:16]) + 17'(q1_ff[15:0]);
   end

   // Stage 9: channel fraction X, then floor(X * 255.999 / 65536) = (X-1) >> 8
   logic [X_W-1:0]   x;
   logic [X_W-1:0]   xm1;
   logic [OUT_W-1:0] level_in;
   logic [OUT_W-1:0] level_ff;

   assign x        = 17'(hi2_ff) + 17'(div_corr(18'(a2_ff)));
   assign xm1      = x - 17'd1;
   assign level_in = (x == '0) ? '0 : xm1[15:8];

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule

`default_nettype wire

/* rtl/hsv_to_rgb888.sv */
// Top level of the HSV to RGB888 pixel converter.
//
// Usage:
//   Drive req_hue, req_saturation and req_brightness and raise start; the
//   word is taken at every rising edge with start high and busy low. busy
//   stays low, so a new pixel may enter on every clock.
//   Each pixel gives one word on rsp_red, rsp_green and rsp_blue, marked by
//   rsp_valid for exactly one cycle. The receiver cannot stall; words leave
//   in the order they entered.
//   Throughput is one pixel per clock, set by a fully pipelined datapath:
//   three stages for the sector split and factor select, then six stages
//   per channel for the 16x32 multiply, the two divisions by 65535 and the
//   quantizer.
//   Synchronous reset clears every valid bit, so no word leaves for items
//   taken before reset. Data registers are not reset.
`default_nettype none

module hsv_to_rgb888
   import h2r_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output wire logic             busy,
   input  wire logic [IN_W-1:0]  req_hue,
   input  wire logic [IN_W-1:0]  req_saturation,
   input  wire logic [IN_W-1:0]  req_brightness,
   output wire logic             rsp_valid,
   output wire logic [OUT_W-1:0] rsp_red,
   output wire logic [OUT_W-1:0] rsp_green,
   output wire logic [OUT_W-1:0] rsp_blue
);

   // Accept a word whenever start is high; the pipeline never backs up
   logic        accept;
   h2r_fac_type fac;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   h2r_factor u_factor (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .fac_out    (fac)
   );

   h2r_chan u_red (
      .clock (clock),
      .v     (fac.v),
      .k     (fac.kr),
      .level (rsp_red)
   );

   h2r_chan u_green (
      .clock (clock),
      .v     (fac.v),
      .k     (fac.kg),
      .level (rsp_green)
   );

   h2r_chan u_blue (
      .clock (clock),
      .v     (fac.v),
      .k     (fac.kb),
      .level (rsp_blue)
   );

   // Advance the valid bits alongside the channel stages
   logic [CHAN_STAGES-1:0] vld_in;
   logic [CHAN_STAGES-1:0] vld_ff;

   assign vld_in = {vld_ff[CHAN_STAGES-2:0], fac.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[CHAN_STAGES-1];

endmodule

`default_nettype wire

/* rtl/h2r_checker.sv */
// Port-level checks for the HSV to RGB888 converter and their binding.
`default_nettype none

module h2r_checker
   import h2r_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic [IN_W-1:0]  req_saturation,
   input wire logic [IN_W-1:0]  req_brightness,
   input wire logic             rsp_valid,
   input wire logic [OUT_W-1:0] rsp_red,
   input wire logic [OUT_W-1:0] rsp_green,
   input wire logic [OUT_W-1:0] rsp_blue
);

   // Every accepted word leaves after the fixed latency
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word did not leave after the pipeline latency");

   // No word leaves without one accepted the latency earlier
   a_latency_bwd : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching accepted word");

   // Zero saturation gives grey
   a_grey : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_saturation, LATENCY) == 16'd0)
         |-> (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("zero saturation did not give equal channels");

   // Zero brightness gives black
   a_black : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_brightness, LATENCY) == 16'd0)
         |-> (rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0))
      else $error("zero brightness did not give black");

endmodule

bind hsv_to_rgb888 h2r_checker u_h2r_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_saturation (req_saturation),
   .req_brightness (req_brightness),
   .rsp_valid      (rsp_valid),
   .rsp_red        (rsp_red),
   .rsp_green      (rsp_green),
   .rsp_blue       (rsp_blue)
);

`default_nettype wire

/* bench/hsv_to_rgb888_tb.sv */
// Self-checking testbench for the HSV to RGB888 pixel converter.
module hsv_to_rgb888_tb;
   import h2r_pkg::*;

   // One RGB word as it leaves the block
   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } rgb_word_type;

   // One pixel to send, with an optional hand-typed answer
   typedef struct {
      logic [IN_W-1:0] hue;
      logic [IN_W-1:0] saturation;
      logic [IN_W-1:0] brightness;
      bit              fixed;
      rgb_word_type    rgb;
   } pixel_row_type;

   localparam logic [63:0] FULL_FACTOR = 64'd65535 * 64'd65536;
   localparam logic [95:0] CHAN_DEN    = 96'd65535 * 96'd65535 * 96'd65536;
   localparam int          RANDOM_PER_PHASE = 317;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             start          = 1'b0;
   logic [IN_W-1:0]  req_hue        = '0;
   logic [IN_W-1:0]  req_saturation = '0;
   logic [IN_W-1:0]  req_brightness = '0;
   wire              busy;
   wire              rsp_valid;
   wire [OUT_W-1:0]  rsp_red;
   wire [OUT_W-1:0]  rsp_green;
   wire [OUT_W-1:0]  rsp_blue;

   // Bench-side tag that travels with the word on the request ports
   bit               pin_fixed = 1'b0;
   rgb_word_type     pin_rgb   = '0;

   rgb_word_type     expected_rgb[$];
   pixel_row_type    directed_rows[$];
   int               fail_count = 0;

   always #1 clock = ~clock;

   hsv_to_rgb888 DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // Round a channel numerator down to a fixed fraction, then scale to 0..255
   function automatic logic [OUT_W-1:0] quantize_channel(input logic [63:0] num);
      logic [95:0] wide;
      logic [63:0] frac;
      logic [63:0] level;
      wide  = {32'd0, num} << FRACTION_BITS;
      frac  = 64'(wide / CHAN_DEN);
      level = (frac * 64'd255999) / (64'd1000 << FRACTION_BITS);
      if (level > 64'd255) begin
         level = 64'd255;
      end
      return level[OUT_W-1:0];
   endfunction

   // Work out the RGB word for one HSV pixel
   function automatic rgb_word_type convert_hsv(input logic [IN_W-1:0] hue,
                                                input logic [IN_W-1:0] sat,
                                                input logic [IN_W-1:0] bri);
      logic [63:0]  hv, sv, vv, h6, fv;
      logic [63:0]  cv, cp, cq, ct, r, g, b;
      sector_type   sector;
      rgb_word_type word;
      hv = {48'd0, hue};
      sv = {48'd0, sat};
      vv = {48'd0, bri};
      h6 = hv * 64'd6;
      sector = sector_type'(h6[18:16]);
      fv = {48'd0, h6[15:0]};
      cv = vv * FULL_FACTOR;
      cp = vv * ((64'd65535 - sv) * 64'd65536);
      cq = vv * (FULL_FACTOR - fv * sv);
      ct = vv * (FULL_FACTOR - (64'd65536 - fv) * sv);
      case (sector)
         SECT_RED_YEL: begin r = cv; g = ct; b = cp; end
         SECT_YEL_GRN: begin r = cq; g = cv; b = cp; end
         SECT_GRN_CYN: begin r = cp; g = cv; b = ct; end
         SECT_CYN_BLU: begin r = cp; g = cq; b = cv; end
         SECT_BLU_MAG: begin r = ct; g = cp; b = cv; end
         default:      begin r = cv; g = cp; b = cq; end
      endcase
      word.red   = quantize_channel(r);
      word.green = quantize_channel(g);
      word.blue  = quantize_channel(b);
      return word;
   endfunction

   // Favor the ends of the range now and then
   function automatic logic [IN_W-1:0] pick_level();
      logic [IN_W-1:0] val;
      case ($urandom_range(9))
         0:       val = 16'd0;
         1:       val = 16'hFFFF;
         2:       val = 16'd1;
         3:       val = 16'hFFFE;
         default: val = 16'($urandom_range(16'hFFFF));
      endcase
      return val;
   endfunction

   // Random pixel, with hues near sector borders part of the time
   function automatic pixel_row_type random_pixel();
      pixel_row_type   row;
      logic [IN_W-1:0] border;
      if ($urandom_range(4) == 0) begin
         case ($urandom_range(5))
            0:       border = 16'd0;
            1:       border = 16'd10923;
            2:       border = 16'd21846;
            3:       border = 16'd32768;
            4:       border = 16'd43691;
            default: border = 16'd54614;
         endcase
         row.hue = border + 16'($urandom_range(2)) - 16'd1;
      end else begin
         row.hue = 16'($urandom_range(16'hFFFF));
      end
      row.saturation = pick_level();
      row.brightness = pick_level();
      row.fixed      = 1'b0;
      row.rgb        = '0;
      return row;
   endfunction

   task automatic add_row(input logic [IN_W-1:0] hue, input logic [IN_W-1:0] sat,
                          input logic [IN_W-1:0] bri, input bit fixed,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      pixel_row_type row;
      row.hue        = hue;
      row.saturation = sat;
      row.brightness = bri;
      row.fixed      = fixed;
      row.rgb        = '{red: r, green: g, blue: b};
      directed_rows.push_back(row);
   endtask

   // Hold start low for random idle cycles, then present the word until taken
   task automatic send_pixel(input pixel_row_type row, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_hue        <= row.hue;
      req_saturation <= row.saturation;
      req_brightness <= row.brightness;
      pin_fixed      <= row.fixed;
      pin_rgb        <= row.rgb;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Record accepted words and check each result against the oldest one
   always @(posedge clock) begin : check_words
      rgb_word_type want;
      if (!reset) begin
         if (start && !busy) begin
            expected_rgb.push_back(pin_fixed ? pin_rgb
                                   : convert_hsv(req_hue, req_saturation, req_brightness));
         end
         if (rsp_valid) begin
            if (expected_rgb.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected word: got r=%0d g=%0d b=%0d",
                           rsp_red, rsp_green, rsp_blue);
               end
            end else begin
               want = expected_rgb.pop_front();
               if (rsp_red !== want.red || rsp_green !== want.green ||
                   rsp_blue !== want.blue) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                              want.red, want.green, want.blue,
                              rsp_red, rsp_green, rsp_blue);
                  end
               end
            end
         end
      end
   end

   // Drive reset, the directed rows, then three random phases
   initial begin : drive_pixels
      int idle_pct[3];
      int wait_cycles;
      idle_pct = '{10, 72, 0};

      // Black, white, pure red and cyan, sector borders, stray bit patterns
      add_row(16'd0,     16'd0,     16'd0,     1'b1, 8'd0,   8'd0,   8'd0);
      add_row(16'd0,     16'd0,     16'hFFFF,  1'b1, 8'd255, 8'd255, 8'd255);
      add_row(16'd0,     16'hFFFF,  16'hFFFF,  1'b1, 8'd255, 8'd0,   8'd0);
      add_row(16'd32768, 16'hFFFF,  16'hFFFF,  1'b1, 8'd0,   8'd255, 8'd255);
      add_row(16'hFFFF,  16'd0,     16'd0,     1'b1, 8'd0,   8'd0,   8'd0);
      add_row(16'd50000, 16'hFFFF,  16'd0,     1'b1, 8'd0,   8'd0,   8'd0);
      add_row(16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd10922, 16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd10923, 16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd21845, 16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd21846, 16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd32767, 16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd43690, 16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd43691, 16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd54613, 16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd54614, 16'hFFFF,  16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'h5555,  16'hAAAA,  16'h5555,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd12345, 16'd1,     16'hFFFF,  1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd40000, 16'hFFFE,  16'd1,     1'b0, 8'd0,   8'd0,   8'd0);
      add_row(16'd20000, 16'd32768, 16'd32768, 1'b0, 8'd0,   8'd0,   8'd0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i], 0);
      end
      for (int ph = 0; ph < 3; ph++) begin
         repeat (RANDOM_PER_PHASE) send_pixel(random_pixel(), idle_pct[ph]);
      end
      start <= 1'b0;

      // Drain the pipeline, then keep the clock running to catch strays
      wait_cycles = 0;
      while (expected_rgb.size() != 0 && wait_cycles < 1000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      fail_count += expected_rgb.size();

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
